>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/mbcd_pkg.sv
// ---------------------------------------------------------------------------
// mbcd_pkg
// Shared types and codes for the multibyte BCD / integer field decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbcd_pkg;

  // width of the multiply-accumulate datapath (96-bit products plus sign room)
  localparam int MAC_W = 98;

  typedef struct packed {
    logic [31:0]      a;
    logic [31:0]      b;
    logic [MAC_W-1:0] addend;
    logic             hi_sh;   // shift product up by 32
  } mac_op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_ENCODING   = 3'd0;
  localparam logic [2:0] CFG_BCD_SINGLE = 3'd1;
  localparam logic [2:0] CFG_LITTLE_END = 3'd2;
  localparam logic [2:0] CFG_UNIT_MASK  = 3'd3;
  localparam logic [2:0] CFG_INVERT     = 3'd4;
  localparam logic [2:0] CFG_SCALE      = 3'd5;
  localparam logic [2:0] CFG_OFFSET     = 3'd6;

  // encoding modes
  localparam logic [1:0] ENC_BINARY = 2'd0;
  localparam logic [1:0] ENC_BCD    = 2'd1;
  localparam logic [1:0] ENC_BOOL   = 2'd2;

  // nibble selection
  localparam logic [1:0] NSEL_WHOLE = 2'd0;
  localparam logic [1:0] NSEL_LOW   = 2'd1;
  localparam logic [1:0] NSEL_HIGH  = 2'd2;

endpackage

>>> rtl/mbcd_mac.sv
// ---------------------------------------------------------------------------
// mbcd_mac
// Shared 32x32 multiplier with accumulate, product optionally shifted by 32.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbcd_mac (
  input  mbcd_pkg::mac_op_t              op,
  output logic [mbcd_pkg::MAC_W-1:0]     res
);

  logic [63:0]                 prod;
  logic [mbcd_pkg::MAC_W-1:0]  prod_ext;

  assign prod = op.a * op.b;

  assign prod_ext = op.hi_sh ? {{(mbcd_pkg::MAC_W-96){1'b0}}, prod, 32'h0}
                             : {{(mbcd_pkg::MAC_W-64){1'b0}}, prod};

  assign res = op.addend + prod_ext;

endmodule

>>> rtl/multibyte_bcd_int_field_decoder_unit.sv
// ---------------------------------------------------------------------------
// multibyte_bcd_int_field_decoder_unit
// A unit is taken in S_IDLE, then combined on the shared 32x32 MAC in S_MA, S_MB
// (plus S_MC, S_MD when little-endian); units past MAX_UNITS are not combined.
// A last unit then passes S_FV (magnitude), S_FA and S_FB (MAC passes), S_FC
// (offset) and S_FIN (round/saturate) before the result item is registered; a
// failed field goes to S_FIN. A new unit is taken only in S_IDLE.
// Reset (rst_n, synchronous): control registers to defaults, field state cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multibyte_bcd_int_field_decoder_unit #(
  parameter int MAX_UNITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // unit input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_unit_byte,
  input  logic               in_from_ram,
  input  logic [1:0]         in_nibble_select,
  input  logic               in_read_ok,
  input  logic               in_last_unit,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_field_value,
  output logic               out_read_good,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int POS_W = $clog2(MAX_UNITS + 1);
  localparam int MW    = mbcd_pkg::MAC_W;

  localparam logic [8:0]  RADIX_DEC  = 9'd10;
  localparam logic [8:0]  RADIX_BCD2 = 9'd100;
  localparam logic [8:0]  RADIX_BIN  = 9'd256;
  localparam logic [63:0] SAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN    = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a unit
    S_MA,     // first MAC pass of combine
    S_MB,     // second MAC pass of combine
    S_MC,     // little-endian weight update, low half
    S_MD,     // little-endian weight update, high half
    S_FV,     // value and scale magnitudes
    S_FA,     // value low word times scale
    S_FB,     // value high word times scale
    S_FC,     // apply sign, add offset
    S_FIN     // round toward zero, saturate, present result
  } state_t;

  // BCD digit above nine reads as zero
  function automatic logic [3:0] bcd_dig(input logic [7:0] d);
    return (d <= 8'd9) ? d[3:0] : 4'd0;
  endfunction

  // ---- registers ----------------------------------------------------------
  state_t            state_r,     state_nxt;
  // configuration
  logic [1:0]        enc_r,       enc_nxt;
  logic              single_r,    single_nxt;
  logic              little_r,    little_nxt;
  logic [7:0]        mask_r,      mask_nxt;
  logic              invert_r,    invert_nxt;
  logic [31:0]       scale_r,     scale_nxt;
  logic [47:0]       offset_r,    offset_nxt;
  // field state
  logic [63:0]       acc_r,       acc_nxt;
  logic [63:0]       weight_r,    weight_nxt;
  logic [POS_W-1:0]  pos_r,       pos_nxt;
  logic              failed_r,    failed_nxt;
  // current unit
  logic [7:0]        uval_r,      uval_nxt;
  logic [8:0]        radix_r,     radix_nxt;
  logic              le_r,        le_nxt;
  logic              last_r,      last_nxt;
  // final scaling datapath
  logic [MW-1:0]     work_r,      work_nxt;
  logic [63:0]       vmag_r,      vmag_nxt;
  logic [31:0]       smag_r,      smag_nxt;
  logic              pneg_r,      pneg_nxt;
  logic [MW-1:0]     sum_r,       sum_nxt;
  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  logic              out_good_r,  out_good_nxt;

  // ---- unit extraction ----------------------------------------------------
  // Nibble selection (skipped for RAM bytes), unit mask, then digit decode.
  logic [7:0] unit_sel;
  logic [7:0] unit_m;
  logic [7:0] uval_c;
  logic [8:0] radix_c;
  logic [7:0] dig_hi;
  logic [7:0] dig_lo;

  always_comb begin
    unit_sel = in_unit_byte;
    if (!in_from_ram) begin
      case (in_nibble_select)
        mbcd_pkg::NSEL_LOW:  unit_sel = {4'h0, in_unit_byte[3:0]};
        mbcd_pkg::NSEL_HIGH: unit_sel = {4'h0, in_unit_byte[7:4]};
        default:             unit_sel = in_unit_byte;  // whole byte, or unused code
      endcase
    end
    unit_m = unit_sel & mask_r;
    dig_hi = {4'h0, bcd_dig({4'h0, unit_m[7:4]})};
    dig_lo = {4'h0, bcd_dig({4'h0, unit_m[3:0]})};
    if (enc_r == mbcd_pkg::ENC_BCD) begin
      if (single_r) begin
        uval_c  = {4'h0, bcd_dig(unit_m)};
        radix_c = RADIX_DEC;
      end else begin
        // hi*10 + lo, at most 99
        uval_c  = (dig_hi << 3) + (dig_hi << 1) + dig_lo;
        radix_c = RADIX_BCD2;
      end
    end else begin
      uval_c  = unit_m;
      radix_c = RADIX_BIN;
    end
  end

  // ---- shared MAC ---------------------------------------------------------
  // Every 64-bit product is built from two 32-bit passes through one
  // multiplier; the high pass lands shifted by 32 on the low pass result.
  mbcd_pkg::mac_op_t mac_op;
  logic [MW-1:0]     mac_res;

  always_comb begin
    mac_op        = '0;
    case (state_r)
      S_MA: begin
        if (le_r) begin
          // acc += uval * weight, low half
          mac_op.a      = weight_r[31:0];
          mac_op.b      = {24'h0, uval_r};
          mac_op.addend = {{(MW-64){1'b0}}, acc_r};
        end else begin
          // acc * radix + uval, low half
          mac_op.a      = acc_r[31:0];
          mac_op.b      = {23'h0, radix_r};
          mac_op.addend = {{(MW-8){1'b0}}, uval_r};
        end
      end
      S_MB: begin
        mac_op.a      = le_r ? weight_r[63:32] : acc_r[63:32];
        mac_op.b      = le_r ? {24'h0, uval_r} : {23'h0, radix_r};
        mac_op.addend = work_r;
        mac_op.hi_sh  = 1'b1;
      end
      S_MC: begin
        mac_op.a = weight_r[31:0];
        mac_op.b = {23'h0, radix_r};
      end
      S_MD: begin
        mac_op.a      = weight_r[63:32];
        mac_op.b      = {23'h0, radix_r};
        mac_op.addend = work_r;
        mac_op.hi_sh  = 1'b1;
      end
      S_FA: begin
        mac_op.a = vmag_r[31:0];
        mac_op.b = smag_r;
      end
      S_FB: begin
        mac_op.a      = vmag_r[63:32];
        mac_op.b      = smag_r;
        mac_op.addend = work_r;
        mac_op.hi_sh  = 1'b1;
      end
      default: mac_op = '0;
    endcase
  end

  mbcd_mac u_mac (
    .op  (mac_op),
    .res (mac_res)
  );

  // ---- final rounding and saturation --------------------------------------
  // Truncation toward zero of sum/65536: bias negative sums by 0xFFFF, then
  // take the arithmetic shift as a slice. Saturate when the quotient does not
  // fit in 64 signed bits.
  logic [MW-1:0]    round_c;
  logic [MW-17:0]   quot_c;
  logic [63:0]      sat_c;
  logic             fits_c;

  always_comb begin
    round_c = sum_r + (sum_r[MW-1] ? {{(MW-16){1'b0}}, 16'hFFFF} : '0);
    quot_c  = round_c[MW-1:16];
    fits_c  = (&quot_c[MW-17:63]) | ~(|quot_c[MW-17:63]);
    if (fits_c) begin
      sat_c = quot_c[63:0];
    end else begin
      sat_c = sum_r[MW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // ---- sequencer ----------------------------------------------------------
  state_t        done_state;
  logic          fail_v;
  logic [63:0]   v_c;
  logic [31:0]   sneg_mag;

  always_comb begin
    // where a unit goes once combined
    if (!last_r) begin
      done_state = S_IDLE;
    end else if (failed_r) begin
      done_state = S_FIN;
    end else begin
      done_state = S_FV;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    enc_nxt       = enc_r;
    single_nxt    = single_r;
    little_nxt    = little_r;
    mask_nxt      = mask_r;
    invert_nxt    = invert_r;
    scale_nxt     = scale_r;
    offset_nxt    = offset_r;
    acc_nxt       = acc_r;
    weight_nxt    = weight_r;
    pos_nxt       = pos_r;
    failed_nxt    = failed_r;
    uval_nxt      = uval_r;
    radix_nxt     = radix_r;
    le_nxt        = le_r;
    last_nxt      = last_r;
    work_nxt      = work_r;
    vmag_nxt      = vmag_r;
    smag_nxt      = smag_r;
    pneg_nxt      = pneg_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_good_nxt  = out_good_r;
    fail_v        = failed_r | ~in_read_ok;
    v_c           = acc_r;
    sneg_mag      = ~scale_r + 32'd1;

    // configuration writes; indexes past the list are dropped
    if (cfg_valid) begin
      case (cfg_index)
        mbcd_pkg::CFG_ENCODING:   enc_nxt    = cfg_data[1:0];
        mbcd_pkg::CFG_BCD_SINGLE: single_nxt = cfg_data[0];
        mbcd_pkg::CFG_LITTLE_END: little_nxt = cfg_data[0];
        mbcd_pkg::CFG_UNIT_MASK:  mask_nxt   = cfg_data[7:0];
        mbcd_pkg::CFG_INVERT:     invert_nxt = cfg_data[0];
        mbcd_pkg::CFG_SCALE:      scale_nxt  = cfg_data[31:0];
        mbcd_pkg::CFG_OFFSET:     offset_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          uval_nxt   = uval_c;
          radix_nxt  = radix_c;
          le_nxt     = little_r;
          last_nxt   = in_last_unit;
          failed_nxt = fail_v;
          if (pos_r < POS_W'(MAX_UNITS)) begin
            state_nxt = S_MA;
          end else if (in_last_unit) begin
            // extra units are not combined, only their marks count
            state_nxt = fail_v ? S_FIN : S_FV;
          end
        end
      end
      S_MA: begin
        work_nxt  = mac_res;
        state_nxt = S_MB;
      end
      S_MB: begin
        acc_nxt = mac_res[63:0];
        if (le_r) begin
          state_nxt = S_MC;
        end else begin
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = done_state;
        end
      end
      S_MC: begin
        work_nxt  = mac_res;
        state_nxt = S_MD;
      end
      S_MD: begin
        weight_nxt = mac_res[63:0];
        pos_nxt    = pos_r + POS_W'(1);
        state_nxt  = done_state;
      end
      S_FV: begin
        if (enc_r == mbcd_pkg::ENC_BOOL) begin
          v_c = {63'h0, (acc_r != 64'h0) ^ invert_r};
        end
        vmag_nxt  = v_c[63] ? (~v_c + 64'd1) : v_c;
        // most negative scale keeps magnitude 0x80000000
        smag_nxt  = scale_r[31] ? sneg_mag : scale_r;
        pneg_nxt  = v_c[63] ^ scale_r[31];
        state_nxt = S_FA;
      end
      S_FA: begin
        work_nxt  = mac_res;
        state_nxt = S_FB;
      end
      S_FB: begin
        work_nxt  = mac_res;
        state_nxt = S_FC;
      end
      S_FC: begin
        sum_nxt   = pneg_r ? ({{(MW-48){offset_r[47]}}, offset_r} - work_r)
                           : ({{(MW-48){offset_r[47]}}, offset_r} + work_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait here while an earlier result still sits in the output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = failed_r ? 64'h0 : sat_c;
          out_good_nxt  = ~failed_r;
          acc_nxt       = 64'h0;
          weight_nxt    = 64'd1;
          pos_nxt       = '0;
          failed_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enc_r       <= mbcd_pkg::ENC_BINARY;
      single_r    <= 1'b0;
      little_r    <= 1'b0;
      mask_r      <= 8'hFF;
      invert_r    <= 1'b0;
      scale_r     <= 32'h0001_0000;
      offset_r    <= 48'h0;
      acc_r       <= 64'h0;
      weight_r    <= 64'd1;
      pos_r       <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enc_r       <= enc_nxt;
      single_r    <= single_nxt;
      little_r    <= little_nxt;
      mask_r      <= mask_nxt;
      invert_r    <= invert_nxt;
      scale_r     <= scale_nxt;
      offset_r    <= offset_nxt;
      acc_r       <= acc_nxt;
      weight_r    <= weight_nxt;
      pos_r       <= pos_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    uval_r      <= uval_nxt;
    radix_r     <= radix_nxt;
    le_r        <= le_nxt;
    last_r      <= last_nxt;
    work_r      <= work_nxt;
    vmag_r      <= vmag_nxt;
    smag_r      <= smag_nxt;
    pneg_r      <= pneg_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_good_r  <= out_good_nxt;
  end

  // ---- ports ---------------------------------------------------------------
  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_read_good   = out_good_r;

  // ---- assertions ---------------------------------------------------------
  `ASSERT_IMPLY(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FIN, "result raised outside final state")
  `ASSERT_NEXT(a_field_cleared, clk, rst_n, (state_r == S_FIN) && (!out_valid_r || out_ready), out_valid_r && (pos_r == '0) && !failed_r, "field state not cleared after result")
  `ASSERT_IMPLY(a_pos_bound, clk, rst_n, 1'b1, pos_r <= POS_W'(MAX_UNITS), "unit position past limit")
  `ASSERT_IMPLY(a_weight_fresh, clk, rst_n, pos_r == '0, weight_r == 64'd1, "digit weight not one at field start")
  `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid_r && !out_good_r, out_value_r == 64'h0, "failed field with nonzero value")

endmodule
